/* hw/rtl/sscl_pkg.sv */
// Shared types and constants for the step sequencer clock.
`timescale 1ns / 1ps

package sscl_pkg;

  // Default sizes for the step and note stores
  localparam int STEPS_DEF     = 16;
  localparam int NOTE_BITS_DEF = 8;

  // Fixed field widths at the ports
  localparam int CFG_W      = 5;
  localparam int CMD_W      = 3;
  localparam int AMT_W      = 9;
  localparam int IDX_W      = 4;
  localparam int OUT_STEP_W = 4;
  localparam int OUT_NOTE_W = 8;
  localparam int TEMPO_W    = 8;
  localparam int PERIOD_W   = 11;
  localparam int ELAPSED_W  = 11;

  // Tempo limits and reset values
  localparam logic [TEMPO_W-1:0]   TEMPO_MIN    = 8'd10;
  localparam logic [TEMPO_W-1:0]   TEMPO_MAX    = 8'd255;
  localparam logic [TEMPO_W-1:0]   TEMPO_RESET  = 8'd120;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 11'd125;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 11'd2047;
  localparam logic [CFG_W-1:0]     LEN_RESET    = 5'd16;

  // Step period divider: 15000 / bpm, one quotient bit per cycle
  localparam int                PERIOD_NUM_W = 14;
  localparam logic [PERIOD_NUM_W-1:0] PERIOD_NUM = 14'd15000;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_PLAY  = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_TEMPO = 3'd3,
    CMD_SEL   = 3'd4,
    CMD_PITCH = 3'd5
  } cmd_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [TEMPO_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/step_sequencer_clock.sv */
// Step sequencer top level: command sequencer around the gate/note RAM.
// Tick, play, stop and unused codes pass through the execute, read and output
// states; pitch and an in-range select also pass a modify state for the RAM
// read-modify-write, and tempo waits in a divide state for the period divider.
// One item in flight; the next beat is taken the cycle after the result is loaded.
// Reset (rst, synchronous) clears all control state and the gate/note valid bits.
`timescale 1ns / 1ps

module step_sequencer_clock #(
  parameter int STEPS     = sscl_pkg::STEPS_DEF,
  parameter int NOTE_BITS = sscl_pkg::NOTE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sscl_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sscl_pkg::CMD_W-1:0]          command,
  input  logic signed [sscl_pkg::AMT_W-1:0]   amount,
  input  logic [sscl_pkg::IDX_W-1:0]          step_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                step_advanced,
  output logic                                position_valid,
  output logic [sscl_pkg::OUT_STEP_W-1:0]     current_step,
  output logic                                gate_on,
  output logic [sscl_pkg::OUT_NOTE_W-1:0]     note_value,
  output logic                                running,
  output logic [sscl_pkg::OUT_STEP_W-1:0]     selected_out,
  output logic [sscl_pkg::TEMPO_W-1:0]        tempo_bpm
);
  import sscl_pkg::*;

  localparam int PW  = $clog2(STEPS);
  localparam int EW  = NOTE_BITS + 1;
  localparam int LW  = (CFG_W > $clog2(STEPS + 1)) ? CFG_W : $clog2(STEPS + 1);
  localparam int SW  = (NOTE_BITS > AMT_W) ? NOTE_BITS : AMT_W;
  localparam int TSW = TEMPO_W + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MOD  = 6'b000100,
    S_DIV  = 6'b001000,
    S_RD   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;

  // control registers
  logic [CFG_W-1:0]     seq_len;
  logic [TEMPO_W-1:0]   tempo;
  logic [PERIOD_W-1:0]  period;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 playing;
  logic [PW-1:0]        position;
  logic                 pos_set;
  logic [PW-1:0]        selected;
  logic                 moved;
  logic [STEPS-1:0]     entry_valid;

  // latched item
  cmd_t                     cmd_q;
  logic signed [AMT_W-1:0]  amt_q;
  logic [IDX_W-1:0]         sidx_q;
  logic [PW-1:0]            edit_addr;

  // RAM ports
  logic          ram_we;
  logic [PW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;
  logic out_free;
  logic sidx_ok;
  logic [PW-1:0] edit_addr_c;

  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign sidx_ok  = (int'(sidx_q) < STEPS);

  // edit address: chosen step for select, selected step for pitch
  assign edit_addr_c = (cmd_q == CMD_SEL) ? PW'(sidx_q) : selected;

  // advance target
  logic [LW-1:0] len_eff;
  logic [LW-1:0] pos_inc;
  logic [PW-1:0] adv_pos;

  always_comb begin
    len_eff = (LW'(seq_len) > LW'(STEPS)) ? LW'(STEPS) : LW'(seq_len);
    pos_inc = LW'(position) + LW'(1);
    if (!pos_set || (pos_inc >= len_eff)) begin
      adv_pos = '0;
    end else begin
      adv_pos = PW'(pos_inc);
    end
  end

  // saturating millisecond count
  logic [ELAPSED_W-1:0] elapsed_inc;
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + ELAPSED_W'(1);

  // tempo adjust, saturated to 10..255
  logic signed [TSW-1:0] tempo_sum;
  logic [TEMPO_W-1:0]    tempo_next;

  always_comb begin
    tempo_sum = $signed({2'b00, tempo}) + $signed({amt_q[AMT_W-1], amt_q});
    if (tempo_sum > $signed({2'b00, TEMPO_MAX})) begin
      tempo_next = TEMPO_MAX;
    end else if (tempo_sum < $signed({2'b00, TEMPO_MIN})) begin
      tempo_next = TEMPO_MIN;
    end else begin
      tempo_next = tempo_sum[TEMPO_W-1:0];
    end
  end

  // read-modify-write of one gate/note entry; unwritten entries read as zero
  logic [EW-1:0]        entry;
  logic                 entry_gate;
  logic [NOTE_BITS-1:0] entry_note;
  logic [SW-1:0]        note_sum;
  logic                 toggle;

  always_comb begin
    entry      = entry_valid[edit_addr] ? ram_rdata : '0;
    entry_gate = entry[NOTE_BITS];
    entry_note = entry[NOTE_BITS-1:0];
    note_sum   = SW'(entry_note) + SW'(amt_q);
    toggle     = (selected == edit_addr) || !entry_gate;
    if (cmd_q == CMD_SEL) begin
      ram_wdata = {entry_gate ^ toggle, entry_note};
    end else begin
      ram_wdata = {entry_gate, note_sum[NOTE_BITS-1:0]};
    end
  end

  assign ram_we    = (state == S_MOD);
  assign ram_raddr = (state == S_EXEC) ? edit_addr_c : position;

  // divider starts on a tempo command, with the new tempo
  assign div_req.start   = (state == S_EXEC) && (cmd_q == CMD_TEMPO);
  assign div_req.divisor = tempo_next;

  // gate/note store; the position read follows the write in the next cycle,
  // so the written entry is always seen
  sscl_ram #(
    .WIDTH (EW),
    .DEPTH (STEPS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (edit_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sscl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= LEN_RESET;
    end else if (cfg_we) begin
      seq_len <= cfg_wdata;
    end
  end

  // latched beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(command);
      amt_q  <= amount;
      sidx_q <= step_index;
    end
    if (state == S_EXEC) begin
      edit_addr <= edit_addr_c;
    end
  end

  // result valid: set when a result is loaded, cleared when it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // command sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tempo       <= TEMPO_RESET;
      period      <= PERIOD_RESET;
      elapsed     <= '0;
      playing     <= 1'b0;
      position    <= '0;
      pos_set     <= 1'b0;
      selected    <= '0;
      moved       <= 1'b0;
      entry_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            moved <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_RD;
          unique case (cmd_q)
            CMD_TICK: begin
              if (playing && (elapsed_inc >= period)) begin
                position <= adv_pos;
                pos_set  <= 1'b1;
                elapsed  <= '0;
                moved    <= 1'b1;
              end else begin
                elapsed <= elapsed_inc;
              end
            end
            CMD_PLAY: begin
              if (!playing) begin
                playing  <= 1'b1;
                position <= adv_pos;
                pos_set  <= 1'b1;
                elapsed  <= '0;
                moved    <= 1'b1;
              end
            end
            CMD_STOP: begin
              if (playing) begin
                playing  <= 1'b0;
                elapsed  <= '0;
                position <= '0;
                pos_set  <= 1'b0;
              end
            end
            CMD_TEMPO: begin
              tempo <= tempo_next;
              state <= S_DIV;
            end
            CMD_SEL: begin
              if (sidx_ok) begin
                state <= S_MOD;
              end
            end
            CMD_PITCH: begin
              state <= S_MOD;
            end
            default: begin
              // unused codes leave the state alone
            end
          endcase
        end
        S_MOD: begin
          entry_valid[edit_addr] <= 1'b1;
          if (cmd_q == CMD_SEL) begin
            selected <= edit_addr;
          end
          state <= S_RD;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            period <= div_rsp.quotient;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat
  logic                 cur_gate;
  logic [NOTE_BITS-1:0] cur_note;

  assign cur_gate = entry_valid[position] ? ram_rdata[NOTE_BITS] : 1'b0;
  assign cur_note = entry_valid[position] ? ram_rdata[NOTE_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      step_advanced  <= moved;
      position_valid <= pos_set;
      running        <= playing;
      selected_out   <= OUT_STEP_W'(selected);
      tempo_bpm      <= tempo;
      if (pos_set) begin
        current_step <= OUT_STEP_W'(position);
        gate_on      <= cur_gate;
        note_value   <= OUT_NOTE_W'(cur_note);
      end else begin
        current_step <= '0;
        gate_on      <= 1'b0;
        note_value   <= '0;
      end
    end
  end

endmodule

/* hw/rtl/sscl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sscl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sscl_div.sv */
// Restoring divider for the step period: 15000 / tempo, one bit per cycle.
`timescale 1ns / 1ps

module sscl_div (
  input  logic               clk,
  input  logic               rst,
  input  sscl_pkg::div_req_t req,
  output sscl_pkg::div_rsp_t rsp
);
  import sscl_pkg::*;

  localparam int CNT_W = $clog2(PERIOD_NUM_W);

  logic                    busy;
  logic                    done;
  logic [CNT_W-1:0]        cnt;
  logic [TEMPO_W-1:0]      divisor;
  logic [TEMPO_W-1:0]      rem;
  logic [PERIOD_NUM_W-1:0] quo;

  logic [TEMPO_W:0]   rem_sh;
  logic [TEMPO_W:0]   diff;
  logic               fits;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh = {rem, quo[PERIOD_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign fits   = (rem_sh >= {1'b0, divisor});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(PERIOD_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= PERIOD_NUM;
    end else if (busy) begin
      rem <= fits ? diff[TEMPO_W-1:0] : rem_sh[TEMPO_W-1:0];
      quo <= {quo[PERIOD_NUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo[PERIOD_W-1:0];

endmodule

/* hw/rtl/sscl_chk.sv */
// Port-level checker for the step sequencer clock, bound to the top level.
`timescale 1ns / 1ps

module sscl_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            step_advanced,
  input logic                            position_valid,
  input logic [sscl_pkg::OUT_STEP_W-1:0] current_step,
  input logic                            gate_on,
  input logic [sscl_pkg::OUT_NOTE_W-1:0] note_value,
  input logic                            running,
  input logic [sscl_pkg::TEMPO_W-1:0]    tempo_bpm
);
  import sscl_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // without a play position the step fields read as zero
  a_no_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_valid |->
      (current_step == '0) && !gate_on && (note_value == '0))
    else $error("step fields nonzero without a position");

  // a position exists exactly while running
  a_pos_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position_valid == running))
    else $error("position and running disagree");

  // an advance only happens while running
  a_adv_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_advanced |-> running && position_valid)
    else $error("advance reported while stopped");

  // tempo never falls below its saturation minimum
  a_tempo_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tempo_bpm >= TEMPO_MIN))
    else $error("tempo below minimum");

endmodule

bind step_sequencer_clock sscl_chk u_sscl_chk (.*);

/* tb/sv/step_sequencer_clock_tb.sv */
// Self-checking testbench for the step sequencer clock.
`timescale 1ns / 1ps

module step_sequencer_clock_tb;
  import sscl_pkg::*;

  // Codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int SEQ_STEPS   = 16;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 7;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [AMT_W-1:0] amt;
    logic [IDX_W-1:0]        idx;
  } seq_cmd_t;

  typedef struct packed {
    logic                  adv;
    logic                  pos_ok;
    logic [OUT_STEP_W-1:0] step;
    logic                  gate;
    logic [OUT_NOTE_W-1:0] note;
    logic                  run;
    logic [OUT_STEP_W-1:0] sel;
    logic [TEMPO_W-1:0]    bpm;
  } seq_status_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [CFG_W-1:0]            cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            command = '0;
  logic signed [AMT_W-1:0]     amount = '0;
  logic [IDX_W-1:0]            step_index = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        step_advanced;
  logic                        position_valid;
  logic [OUT_STEP_W-1:0]       current_step;
  logic                        gate_on;
  logic [OUT_NOTE_W-1:0]       note_value;
  logic                        running;
  logic [OUT_STEP_W-1:0]       selected_out;
  logic [TEMPO_W-1:0]          tempo_bpm;

  step_sequencer_clock dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .amount         (amount),
    .step_index     (step_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .step_advanced  (step_advanced),
    .position_valid (position_valid),
    .current_step   (current_step),
    .gate_on        (gate_on),
    .note_value     (note_value),
    .running        (running),
    .selected_out   (selected_out),
    .tempo_bpm      (tempo_bpm)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sequencer state as the testbench expects it
  logic [CFG_W-1:0]      seq_len;
  logic [TEMPO_W-1:0]    tempo_now;
  logic [PERIOD_W-1:0]   period_ms;
  logic [ELAPSED_W-1:0]  elapsed_ms;
  logic                  playing;
  logic [3:0]            play_pos;
  logic                  pos_known;
  logic [3:0]            sel_step;
  logic                  gates [SEQ_STEPS];
  logic [7:0]            notes [SEQ_STEPS];

  seq_cmd_t    cmd_backlog [$];
  seq_status_t status_due [$];
  seq_cmd_t    cur_beat, next_beat;
  seq_status_t got, want;

  int issued_total = 0;
  int accepted_total = 0;
  int fail_count = 0;
  int advances = 0;
  int wraps = 0;
  int lengths_used = 0;
  int idle_odds = 0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic void reset_model();
    seq_len    = LEN_RESET;
    tempo_now  = TEMPO_RESET;
    period_ms  = PERIOD_RESET;
    elapsed_ms = '0;
    playing    = 1'b0;
    play_pos   = '0;
    pos_known  = 1'b0;
    sel_step   = '0;
    for (int i = 0; i < SEQ_STEPS; i++) begin
      gates[i] = 1'b0;
      notes[i] = '0;
    end
  endfunction

  // Move the play position one step, wrapping at the effective length
  function automatic void step_forward();
    int lim;
    int nxt;
    lim = (int'(seq_len) > SEQ_STEPS) ? SEQ_STEPS : int'(seq_len);
    if (!pos_known) begin
      nxt = 0;
    end else begin
      nxt = int'(play_pos) + 1;
      if (nxt >= lim) begin
        nxt = 0;
        wraps++;
      end
    end
    play_pos   = 4'(nxt);
    pos_known  = 1'b1;
    elapsed_ms = '0;
  endfunction

  // Apply one command to the expected state and return the status beat
  function automatic seq_status_t apply_command(seq_cmd_t c);
    seq_status_t r;
    int t;
    logic moved;
    moved = 1'b0;
    case (c.cmd)
      CMD_TICK: begin
        if (elapsed_ms < ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
        if (playing && elapsed_ms >= period_ms) begin
          step_forward();
          moved = 1'b1;
        end
      end
      CMD_PLAY: begin
        if (!playing) begin
          playing    = 1'b1;
          elapsed_ms = '0;
          step_forward();
          moved = 1'b1;
        end
      end
      CMD_STOP: begin
        if (playing) begin
          playing    = 1'b0;
          elapsed_ms = '0;
          play_pos   = '0;
          pos_known  = 1'b0;
        end
      end
      CMD_TEMPO: begin
        t = int'(tempo_now) + int'($signed(c.amt));
        if (t > int'(TEMPO_MAX)) t = int'(TEMPO_MAX);
        else if (t < int'(TEMPO_MIN)) t = int'(TEMPO_MIN);
        tempo_now = TEMPO_W'(t);
        period_ms = PERIOD_W'(int'(PERIOD_NUM) / t);
      end
      CMD_SEL: begin
        if (sel_step == c.idx || !gates[c.idx]) gates[c.idx] = !gates[c.idx];
        sel_step = c.idx;
      end
      CMD_PITCH: begin
        notes[sel_step] = notes[sel_step] + c.amt[7:0];
      end
      default: begin
      end
    endcase
    r.adv    = moved;
    r.pos_ok = pos_known;
    r.step   = pos_known ? play_pos : '0;
    r.gate   = pos_known ? gates[play_pos] : 1'b0;
    r.note   = pos_known ? notes[play_pos] : '0;
    r.run    = playing;
    r.sel    = sel_step;
    r.bpm    = tempo_now;
    return r;
  endfunction

  function automatic string show_status(seq_status_t s);
    return $sformatf("adv=%0d pv=%0d step=%0d gate=%0d note=%0d run=%0d sel=%0d bpm=%0d",
                     s.adv, s.pos_ok, s.step, s.gate, s.note, s.run, s.sel, s.bpm);
  endfunction

  // Command driver: predicts on each accepted beat, idles in random bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      reset_model();
    end else begin
      if (in_valid && !in_stall) begin
        cur_beat = {command, amount, step_index};
        status_due.push_back(apply_command(cur_beat));
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
          gap_left = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          next_beat = cmd_backlog.pop_front();
          in_valid   <= 1'b1;
          command    <= next_beat.cmd;
          amount     <= next_beat.amt;
          step_index <= next_beat.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: checks each accepted beat, stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {step_advanced, position_valid, current_step, gate_on, note_value, running,
               selected_out, tempo_bpm};
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected status beat: %s", show_status(got));
        end else begin
          want = status_due.pop_front();
          if (want.adv) advances++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("status mismatch at %0t", $realtime);
              $display("  expected %s", show_status(want));
              $display("  actual   %s", show_status(got));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int amt, input int idx);
    seq_cmd_t c;
    c.cmd = cmd;
    c.amt = AMT_W'(amt);
    c.idx = IDX_W'(idx);
    cmd_backlog.push_back(c);
    issued_total++;
  endtask

  function automatic int rand_amt();
    return int'($urandom_range(0, 510)) - 255;
  endfunction

  // Wait until every command is accepted and every status beat checked
  task automatic drain();
    while (accepted_total != issued_total || status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input int len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_we  <= 1'b0;
    seq_len = CFG_W'(len);
    lengths_used++;
  endtask

  // One phase of random traffic; tick-heavy phases send long runs of ticks
  task automatic gen_phase(input int n, input bit ticky);
    int made;
    int r;
    int burst;
    made = 3;
    push_cmd(CMD_STOP, rand_amt(), $urandom_range(0, 15));
    push_cmd(CMD_TEMPO, 255, $urandom_range(0, 15));
    push_cmd(CMD_PLAY, rand_amt(), $urandom_range(0, 15));
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < (ticky ? 96 : 50)) begin
        burst = $urandom_range(1, ticky ? 60 : 30);
        repeat (burst) push_cmd(CMD_TICK, rand_amt(), $urandom_range(0, 15));
        made += burst;
      end else if (ticky) begin
        if (r < 98) push_cmd(CMD_SEL, rand_amt(), $urandom_range(0, 15));
        else push_cmd(CMD_PITCH, rand_amt(), $urandom_range(0, 15));
        made++;
      end else if (r < 60) begin
        push_cmd(CMD_TEMPO, $urandom_range(0, 1) ? rand_amt() : $urandom_range(0, 60) - 30,
                 $urandom_range(0, 15));
        made++;
      end else if (r < 68) begin
        push_cmd(CMD_SEL, rand_amt(), $urandom_range(0, 15));
        made++;
      end else if (r < 76) begin
        push_cmd(CMD_PITCH, rand_amt(), $urandom_range(0, 15));
        made++;
      end else if (r < 80) begin
        // edit a step: select it, then nudge its note
        burst = $urandom_range(1, 3);
        push_cmd(CMD_SEL, rand_amt(), $urandom_range(0, 15));
        repeat (burst) push_cmd(CMD_PITCH, rand_amt(), $urandom_range(0, 15));
        made += burst + 1;
      end else if (r < 86) begin
        push_cmd(CMD_PLAY, rand_amt(), $urandom_range(0, 15));
        made++;
      end else if (r < 91) begin
        push_cmd(CMD_STOP, rand_amt(), $urandom_range(0, 15));
        made++;
      end else if (r < 95) begin
        push_cmd($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO, rand_amt(),
                 $urandom_range(0, 15));
        made++;
      end else begin
        push_cmd(CMD_TEMPO, 255, $urandom_range(0, 15));
        made++;
      end
    end
  endtask

  // Phase plan: length setting (-1 picks one), size, idling odds, tick-heavy
  int  plan_len   [PHASES] = '{1, 2, 0, 31, -1, 17, 16};
  int  plan_items [PHASES] = '{100, 100, 100, 830, 100, 100, 100};
  int  plan_idle  [PHASES] = '{4, 8, 0, 5, 12, 3, 0};
  bit  plan_ticky [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    idle_odds = 6;

    // directed: reset state, note wrap, gate toggle rules, tempo limits, play/stop
    push_cmd(CMD_SPARE_HI, 0, 0);
    push_cmd(CMD_SPARE_LO, -1, 15);
    push_cmd(CMD_TICK, 0, 0);
    push_cmd(CMD_PITCH, 255, 0);
    push_cmd(CMD_PITCH, 1, 0);
    push_cmd(CMD_PITCH, -255, 0);
    push_cmd(CMD_SEL, 0, 0);
    push_cmd(CMD_SEL, 0, 0);
    push_cmd(CMD_SEL, 0, 15);
    push_cmd(CMD_SEL, 0, 3);
    push_cmd(CMD_SEL, 0, 15);
    push_cmd(CMD_TEMPO, 255, 0);
    push_cmd(CMD_TEMPO, -255, 0);
    push_cmd(CMD_TEMPO, 200, 0);
    push_cmd(CMD_PLAY, 0, 0);
    push_cmd(CMD_PLAY, 0, 0);
    push_cmd(CMD_TICK, 0, 0);
    push_cmd(CMD_STOP, 0, 0);
    push_cmd(CMD_STOP, 0, 0);
    push_cmd(CMD_PLAY, 0, 0);
    push_cmd(CMD_TEMPO, 255, 0);
    push_cmd(CMD_TICK, -1, 15);
    push_cmd(CMD_STOP, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_length(plan_len[p] < 0 ? $urandom_range(3, 15) : plan_len[p]);
      idle_odds = plan_idle[p];
      gen_phase(plan_items[p], plan_ticky[p]);
    end

    drain();
    repeat (24) @(posedge clk);
    $display("Checked %0d commands over %0d length settings", accepted_total, lengths_used);
    $display("  with %0d step advances and %0d wraps to step 0", advances, wraps);
    if (fail_count == 0) begin
      $display("step_sequencer_clock regression: pass");
    end else begin
      $display("step_sequencer_clock regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("step_sequencer_clock regression: fail");
    $finish;
  end

endmodule
